### hdl/tirdec_pkg.sv
// ----------------------------------------------------------------------------
// tirdec_pkg
// Shared types and constants for the tagged integer record decoder.
// ----------------------------------------------------------------------------
package tirdec_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;

    // tag bytes
    localparam logic [7:0] TAG_BIT      = 8'h00;
    localparam logic [7:0] TAG_SIGNED   = 8'h02;
    localparam logic [7:0] TAG_UNSIGNED = 8'h04;

    // length byte fields
    localparam logic [7:0] SIGN_MASK = 8'h80;
    localparam logic [7:0] LEN_MASK  = 8'h7F;

    // stream word kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADTAG = 2'd1,
        ST_END    = 2'd2,
        ST_LONG   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        VT_BIT      = 2'd0,
        VT_SIGNED   = 2'd1,
        VT_UNSIGNED = 2'd2
    } vtype_t;

    // what the back end does with a queued command
    typedef enum logic [1:0] {
        CMD_EMIT  = 2'd0,  // result fully known, no accumulator use
        CMD_SHIFT = 2'd1,  // shift a magnitude byte in, no result
        CMD_LAST  = 2'd2   // shift the final magnitude byte in and emit
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic       first;     // first magnitude byte: accumulator starts at zero
        logic [7:0] data_byte;
        status_t    status;
        vtype_t     vtype;
        logic       neg;
    } cmd_t;

endpackage

### hdl/tirdec_if.sv
// ----------------------------------------------------------------------------
// tirdec_if
// Valid/ready channels for stream bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface tirdec_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface tirdec_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  value_type;
    logic [63:0] value_bits;
    logic [7:0]  offending_tag;

    modport source (output valid, output status, output value_type, output value_bits,
                    output offending_tag, input ready);
    modport sink   (input valid, input status, input value_type, input value_bits,
                    input offending_tag, output ready);
endinterface

### hdl/tagged_integer_record_decoder_top.sv
// ----------------------------------------------------------------------------
// tagged_integer_record_decoder_top - tagged integer/bit record decoder
// The last byte's command is queued, then its result is registered at the output.
// Throughput: one stream word per cycle; stalls only when a stalled output fills the queue.
// Reset: async active-low rst_n; parser awaits a tag, queue and output are empty.
// ----------------------------------------------------------------------------
module tagged_integer_record_decoder_top #(
    parameter int VALUE_BITS = tirdec_pkg::VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tirdec_in_if.sink     stream,
    tirdec_out_if.source  result
);

    // Structure:
    //   front : parses tag and length bytes, holds the record state (phase,
    //           type, sign, bytes left, too-long flag) and turns every byte
    //           that matters into one command word.
    //   queue : two-entry command queue; the front only stalls when it is full.
    //   back  : owns the magnitude accumulator, does the final negation and
    //           keeps the result in an output register, so a new command can
    //           be taken in the same cycle the old result is taken.
    // Tag and length bytes of integer records make no command; they only
    // update front state.

    logic              q_full;
    logic              q_push;
    tirdec_pkg::cmd_t  q_push_cmd;
    logic              q_pop;
    logic              q_head_valid;
    tirdec_pkg::cmd_t  q_head_cmd;

    tirdec_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stream.valid),
        .in_ready  (stream.ready),
        .kind      (stream.kind),
        .data_byte (stream.data_byte),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (q_push_cmd)
    );

    tirdec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // the accumulator width follows VALUE_BITS; results are always 64 bits
    tirdec_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_head_valid),
        .head_cmd      (q_head_cmd),
        .pop           (q_pop),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .status        (result.status),
        .value_type    (result.value_type),
        .value_bits    (result.value_bits),
        .offending_tag (result.offending_tag)
    );

endmodule

### hdl/tirdec_front.sv
// ----------------------------------------------------------------------------
// tirdec_front
// Record parser: tracks tag/length/data phase and issues back-end commands.
// ----------------------------------------------------------------------------
module tirdec_front #(
    parameter int VALUE_BITS = tirdec_pkg::VALUE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [7:0]        data_byte,
    input  logic              q_full,
    output logic              push,
    output tirdec_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        PH_TAG  = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    phase_t                     phase_reg, phase_next;
    tirdec_pkg::vtype_t         type_reg, type_next;
    logic                       neg_reg, neg_next;
    logic [7:0]                 left_reg, left_next;
    logic                       ovf_reg, ovf_next;
    logic                       first_reg, first_next;

    logic                       accept;
    logic [7:0]                 len_plus1;
    logic [10:0]                len_bits;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign len_plus1 = (data_byte & tirdec_pkg::LEN_MASK) + 8'd1;
    assign len_bits  = {len_plus1, 3'b000};

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        neg_next   = neg_reg;
        left_next  = left_reg;
        ovf_next   = ovf_reg;
        first_next = first_reg;
        push       = 1'b0;
        cmd.op        = tirdec_pkg::CMD_EMIT;
        cmd.first     = first_reg;
        cmd.data_byte = data_byte;
        cmd.status    = tirdec_pkg::ST_OK;
        cmd.vtype     = type_reg;
        cmd.neg       = neg_reg;

        if (accept)
        begin
            if (kind == tirdec_pkg::KIND_END)
            begin
                push       = 1'b1;
                cmd.status = tirdec_pkg::ST_END;
                cmd.vtype  = (phase_reg == PH_TAG) ? tirdec_pkg::VT_BIT : type_reg;
                phase_next = PH_TAG;
                type_next  = tirdec_pkg::VT_BIT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_TAG:
                    begin
                        unique case (data_byte)
                            tirdec_pkg::TAG_BIT:
                            begin
                                type_next  = tirdec_pkg::VT_BIT;
                                phase_next = PH_LEN;
                            end
                            tirdec_pkg::TAG_SIGNED:
                            begin
                                type_next  = tirdec_pkg::VT_SIGNED;
                                phase_next = PH_LEN;
                            end
                            tirdec_pkg::TAG_UNSIGNED:
                            begin
                                type_next  = tirdec_pkg::VT_UNSIGNED;
                                phase_next = PH_LEN;
                            end
                            default:
                            begin
                                push       = 1'b1;
                                cmd.status = tirdec_pkg::ST_BADTAG;
                                cmd.vtype  = tirdec_pkg::VT_BIT;
                            end
                        endcase
                    end
                    PH_LEN:
                    begin
                        if (type_reg == tirdec_pkg::VT_BIT)
                        begin
                            // bit record: this byte carries the value; the back end reports any nonzero byte as one
                            push       = 1'b1;
                            cmd.vtype  = tirdec_pkg::VT_BIT;
                            phase_next = PH_TAG;
                        end
                        else
                        begin
                            neg_next   = (type_reg == tirdec_pkg::VT_SIGNED) &&
                                         ((data_byte & tirdec_pkg::SIGN_MASK) != 8'd0);
                            left_next  = len_plus1;
                            ovf_next   = len_bits > 11'(VALUE_BITS);
                            first_next = 1'b1;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        push       = 1'b1;
                        first_next = 1'b0;
                        left_next  = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            cmd.op     = tirdec_pkg::CMD_LAST;
                            cmd.status = ovf_reg ? tirdec_pkg::ST_LONG : tirdec_pkg::ST_OK;
                            phase_next = PH_TAG;
                            type_next  = tirdec_pkg::VT_BIT;
                        end
                        else
                        begin
                            cmd.op = tirdec_pkg::CMD_SHIFT;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_TAG;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            type_reg  <= tirdec_pkg::VT_BIT;
            neg_reg   <= 1'b0;
            left_reg  <= 8'd0;
            ovf_reg   <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            neg_reg   <= neg_next;
            left_reg  <= left_next;
            ovf_reg   <= ovf_next;
            first_reg <= first_next;
        end
    end

`ifndef SYNTHESIS
    // a record in its data phase always has at least one byte to come
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> left_reg != 8'd0)
        else $error("data phase with no bytes left");

    // the final magnitude byte, and only it, closes the record
    a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == tirdec_pkg::KIND_DATA && phase_reg == PH_DATA |->
        ((cmd.op == tirdec_pkg::CMD_LAST) == (left_reg == 8'd1)))
        else $error("record closed at wrong byte");
`endif

endmodule

### hdl/tirdec_queue.sv
// ----------------------------------------------------------------------------
// tirdec_queue
// Short command queue between parser and executor.
// ----------------------------------------------------------------------------
module tirdec_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tirdec_pkg::cmd_t  push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tirdec_pkg::cmd_t  head_cmd
);

    localparam int PTR_W = (tirdec_pkg::QUEUE_DEPTH > 1) ? $clog2(tirdec_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tirdec_pkg::QUEUE_DEPTH + 1);

    tirdec_pkg::cmd_t  entry_reg [tirdec_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(tirdec_pkg::QUEUE_DEPTH - 1)) r = '0;
        else                                           r = p + PTR_W'(1);
        return r;
    endfunction

    assign full       = (count_reg == CNT_W'(tirdec_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)      count_next = count_reg + CNT_W'(1);
        else if (pop && !push) count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !head_valid))
        else $error("command queue overrun or underrun");
`endif

endmodule

### hdl/tirdec_back.sv
// ----------------------------------------------------------------------------
// tirdec_back
// Executor: magnitude accumulator, negation and result register.
// ----------------------------------------------------------------------------
module tirdec_back #(
    parameter int VALUE_BITS = tirdec_pkg::VALUE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tirdec_pkg::cmd_t  head_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [1:0]        value_type,
    output logic [63:0]       value_bits,
    output logic [7:0]        offending_tag
);

    logic [VALUE_BITS-1:0]   acc_reg;
    logic [VALUE_BITS-1:0]   acc_base;
    logic [VALUE_BITS+7:0]   acc_join;
    logic [VALUE_BITS-1:0]   acc_next;
    logic [63:0]             mag;
    logic [63:0]             value_calc;
    logic [7:0]              tag_calc;

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              status_reg;
    logic [1:0]              vtype_reg;
    logic [63:0]             value_reg;
    logic [7:0]              tag_reg;

    logic                    emits;
    logic                    out_free;

    assign emits    = (head_cmd.op != tirdec_pkg::CMD_SHIFT);
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = head_valid && (!emits || out_free);

    assign acc_base = head_cmd.first ? '0 : acc_reg;
    assign acc_join = {acc_base, head_cmd.data_byte};
    assign acc_next = acc_join[VALUE_BITS-1:0];
    assign mag      = 64'(acc_next);

    always_comb
    begin
        tag_calc = (head_cmd.status == tirdec_pkg::ST_BADTAG) ? head_cmd.data_byte : 8'd0;
        if (head_cmd.op == tirdec_pkg::CMD_EMIT)
        begin
            // only a finished bit record carries a value here
            value_calc = (head_cmd.status == tirdec_pkg::ST_OK) ?
                         {63'd0, (head_cmd.data_byte != 8'd0)} : 64'd0;
        end
        else
        begin
            value_calc = head_cmd.neg ? (64'd0 - mag) : mag;
        end
        out_valid_next = out_valid_reg;
        if (out_ready)         out_valid_next = 1'b0;
        if (pop && emits)      out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.op != tirdec_pkg::CMD_EMIT)
        begin
            acc_reg <= acc_next;
        end
        if (pop && emits)
        begin
            status_reg <= head_cmd.status;
            vtype_reg  <= head_cmd.vtype;
            value_reg  <= value_calc;
            tag_reg    <= tag_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign value_type    = vtype_reg;
    assign value_bits    = value_reg;
    assign offending_tag = tag_reg;

`ifndef SYNTHESIS
    // a shift-only command never makes a result appear
    a_shift_silent: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !emits |=> out_valid_reg == $past(out_valid_reg && !out_ready))
        else $error("shift command produced a result");
`endif

endmodule
